// ----- rtl/core/mrh_pkg.sv -----
// Shared types and constants for the monotone radix heap.
// Holds the item structs, action and status codes and the cell control bundle.
// No dependencies.
package mrh_pkg;

    localparam int CAPACITY = 256;
    localparam int KEY_BITS = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int OCC_W    = 9;

    localparam logic [1:0] ACT_PUSH  = 2'd0;
    localparam logic [1:0] ACT_POP   = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_BELOW = 2'd3;

    typedef enum logic [1:0] {
        OP_IDLE  = 2'd0,
        OP_PUSH  = 2'd1,
        OP_POP   = 2'd2,
        OP_CLEAR = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t            op;
        logic [KEY_BITS-1:0] key;
    } cell_ctrl_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] key_in;
    } req_item_t;

    typedef struct packed {
        logic [31:0]      key_out;
        logic [1:0]       status;
        logic [OCC_W-1:0] occupancy;
    } rsp_item_t;

endpackage

// ----- rtl/core/monotone_radix_heap_top.sv -----
// Top level of the monotone radix heap: request and response channels,
// occupancy and last-popped tracking, and the chain of key cells.
// Depends on mrh_pkg and mrh_cell.
//
// Usage: each request item carries an action (push, pop or clear) and a key.
// A request is accepted at a clock edge where req_valid is high and req_stall
// is low. Every request produces exactly one response item on rsp, carrying
// the popped key (zero unless a pop succeeded), a status and the occupancy.
// The keys are held in ascending order in a chain of 256 cells; a push is
// inserted by every cell comparing itself with the key in the same cycle and
// shifting one place, and a pop shifts the whole chain one place to the head.
// rsp_valid rises in the cycle after acceptance, and the block takes one item
// per cycle while no stalled response holds it back.
// The response sits in an output register; while rsp_stall holds it, the
// block raises req_stall and takes no further request.
// Reset empties the chain, clears the occupancy and the last popped key and
// leaves no response pending; the block is ready to take a request right after it.
module monotone_radix_heap_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  mrh_pkg::req_item_t  req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output mrh_pkg::rsp_item_t  rsp
);

    logic [mrh_pkg::CNT_W-1:0]    count_reg;
    logic [mrh_pkg::CNT_W-1:0]    count_next;
    logic [mrh_pkg::KEY_BITS-1:0] last_reg;
    logic [mrh_pkg::KEY_BITS-1:0] last_next;
    logic                         rsp_valid_reg;
    logic                         rsp_valid_next;
    mrh_pkg::rsp_item_t           rsp_reg;
    mrh_pkg::rsp_item_t           rsp_next;

    logic                         accept;
    logic                         full;
    logic                         empty;
    logic [mrh_pkg::KEY_BITS-1:0] req_key;
    mrh_pkg::cell_op_t            op;
    mrh_pkg::cell_ctrl_t          ctrl;

    logic [mrh_pkg::KEY_BITS-1:0] cell_key   [mrh_pkg::CAPACITY];
    logic                         cell_valid [mrh_pkg::CAPACITY];
    logic                         cell_gt    [mrh_pkg::CAPACITY];

    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;
    assign full      = (count_reg == mrh_pkg::CNT_W'(mrh_pkg::CAPACITY));
    assign empty     = (count_reg == '0);
    assign req_key   = req.key_in[mrh_pkg::KEY_BITS-1:0];

    always_comb
    begin
        op         = mrh_pkg::OP_IDLE;
        count_next = count_reg;
        last_next  = last_reg;
        rsp_next.key_out = '0;
        rsp_next.status  = mrh_pkg::ST_OK;
        case (req.action)
            mrh_pkg::ACT_PUSH:
            begin
                if (full)
                begin
                    rsp_next.status = mrh_pkg::ST_FULL;
                end
                else if (req_key < last_reg)
                begin
                    rsp_next.status = mrh_pkg::ST_BELOW;
                end
                else
                begin
                    op         = mrh_pkg::OP_PUSH;
                    count_next = count_reg + 1'b1;
                end
            end
            mrh_pkg::ACT_POP:
            begin
                if (empty)
                begin
                    rsp_next.status = mrh_pkg::ST_EMPTY;
                end
                else
                begin
                    op               = mrh_pkg::OP_POP;
                    count_next       = count_reg - 1'b1;
                    last_next        = cell_key[0];
                    rsp_next.key_out = 32'(cell_key[0]);
                end
            end
            mrh_pkg::ACT_CLEAR:
            begin
                op         = mrh_pkg::OP_CLEAR;
                count_next = '0;
                last_next  = '0;
            end
            default:
            begin
                op = mrh_pkg::OP_IDLE;
            end
        endcase
        rsp_next.occupancy = mrh_pkg::OCC_W'(count_next);
    end

    assign ctrl.op  = accept ? op : mrh_pkg::OP_IDLE;
    assign ctrl.key = req_key;

    assign rsp_valid_next = accept || (rsp_valid_reg && rsp_stall);

    genvar i;
    generate
        for (i = 0; i < mrh_pkg::CAPACITY; i++)
        begin : g_cell
            logic [mrh_pkg::KEY_BITS-1:0] lk;
            logic                         lv;
            logic                         lg;
            logic [mrh_pkg::KEY_BITS-1:0] rk;
            logic                         rv;

            if (i == 0)
            begin : g_head
                assign lk = '0;
                assign lv = 1'b1;
                assign lg = 1'b0;
            end
            else
            begin : g_body
                assign lk = cell_key[i-1];
                assign lv = cell_valid[i-1];
                assign lg = cell_gt[i-1];
            end

            if (i == mrh_pkg::CAPACITY - 1)
            begin : g_tail
                assign rk = '0;
                assign rv = 1'b0;
            end
            else
            begin : g_inner
                assign rk = cell_key[i+1];
                assign rv = cell_valid[i+1];
            end

            mrh_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .left_key    (lk),
                .left_valid  (lv),
                .left_gt     (lg),
                .right_key   (rk),
                .right_valid (rv),
                .key         (cell_key[i]),
                .valid       (cell_valid[i]),
                .gt          (cell_gt[i])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            last_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            if (accept)
            begin
                count_reg <= count_next;
                last_reg  <= last_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ----- rtl/core/mrh_cell.sv -----
// One cell of the sorted key chain: holds one key and its valid flag.
// Inserts by shifting towards the tail and pops by shifting towards the head.
// Depends on mrh_pkg.
module mrh_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mrh_pkg::cell_ctrl_t           ctrl,
    input  logic [mrh_pkg::KEY_BITS-1:0]  left_key,
    input  logic                          left_valid,
    input  logic                          left_gt,
    input  logic [mrh_pkg::KEY_BITS-1:0]  right_key,
    input  logic                          right_valid,
    output logic [mrh_pkg::KEY_BITS-1:0]  key,
    output logic                          valid,
    output logic                          gt
);

    logic [mrh_pkg::KEY_BITS-1:0] key_reg;
    logic [mrh_pkg::KEY_BITS-1:0] key_next;
    logic                         valid_reg;
    logic                         valid_next;
    logic                         take;

    assign gt   = valid_reg && (key_reg > ctrl.key);
    assign take = gt || (!valid_reg && left_valid);

    always_comb
    begin
        key_next   = key_reg;
        valid_next = valid_reg;
        case (ctrl.op)
            mrh_pkg::OP_PUSH:
            begin
                if (take)
                begin
                    key_next   = left_gt ? left_key : ctrl.key;
                    valid_next = 1'b1;
                end
            end
            mrh_pkg::OP_POP:
            begin
                key_next   = right_key;
                valid_next = right_valid;
            end
            mrh_pkg::OP_CLEAR:
            begin
                valid_next = 1'b0;
            end
            default:
            begin
                key_next   = key_reg;
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign key   = key_reg;
    assign valid = valid_reg;

endmodule
